@@ rtl/wfsc_pkg.sv @@
// wfsc_pkg: shared types, codes and constants of the frame statistics counter
// no dependencies; imported by every module of the block
package wfsc_pkg;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int RATE_SCALE_DEF   = 1000;

  localparam int STAT_W    = 5;
  localparam int VALUE_W   = 33;
  localparam int NUM_CNT   = 13;
  localparam int TOTAL_W   = 40;
  localparam int DIV_W     = 42;
  localparam int DEN_W     = 32;
  localparam int AVG_W     = 9;
  localparam int RATE_W    = 32;

  // operation codes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_SNAP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // radio class codes
  localparam logic [1:0] CLASS_MISC = 2'd0;

  // statistic ids
  localparam logic [STAT_W-1:0] ID_TOTAL      = 5'd0;
  localparam logic [STAT_W-1:0] ID_MGMT       = 5'd1;
  localparam logic [STAT_W-1:0] ID_CTRL       = 5'd2;
  localparam logic [STAT_W-1:0] ID_DATA       = 5'd3;
  localparam logic [STAT_W-1:0] ID_BEACON     = 5'd4;
  localparam logic [STAT_W-1:0] ID_PROBE_REQ  = 5'd5;
  localparam logic [STAT_W-1:0] ID_PROBE_RESP = 5'd6;
  localparam logic [STAT_W-1:0] ID_ASSOC_REQ  = 5'd7;
  localparam logic [STAT_W-1:0] ID_ASSOC_RESP = 5'd8;
  localparam logic [STAT_W-1:0] ID_DEAUTH     = 5'd9;
  localparam logic [STAT_W-1:0] ID_DISASSOC   = 5'd10;
  localparam logic [STAT_W-1:0] ID_MALFORMED  = 5'd11;
  localparam logic [STAT_W-1:0] ID_OVERFLOW   = 5'd12;
  localparam logic [STAT_W-1:0] ID_AVG        = 5'd13;
  localparam logic [STAT_W-1:0] ID_PEAK       = 5'd14;
  localparam logic [STAT_W-1:0] ID_RATE       = 5'd15;
  localparam logic [STAT_W-1:0] ID_INTERVAL   = 5'd16;
  localparam logic [STAT_W-1:0] ID_ELAPSED    = 5'd17;

  typedef enum logic [1:0] {
    CMD_FRAME,
    CMD_BAD,
    CMD_SNAP,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [1:0]         ftype;
    logic               sub_hit;
    logic [3:0]         sub_idx;
    logic signed [7:0]  rssi;
    logic [31:0]        now_ms;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_AVG,
    ST_DIV_RATE,
    ST_EMIT
  } back_state_t;

  // management subtype to counter index, msb set on a tracked subtype
  function automatic logic [4:0] subtype_map(input logic [3:0] sub);
    logic [4:0] r;
    case (sub)
      4'd0:    r = {1'b1, ID_ASSOC_REQ[3:0]};
      4'd1:    r = {1'b1, ID_ASSOC_RESP[3:0]};
      4'd4:    r = {1'b1, ID_PROBE_REQ[3:0]};
      4'd5:    r = {1'b1, ID_PROBE_RESP[3:0]};
      4'd8:    r = {1'b1, ID_BEACON[3:0]};
      4'd10:   r = {1'b1, ID_DISASSOC[3:0]};
      4'd12:   r = {1'b1, ID_DEAUTH[3:0]};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/wifi_frame_statistics_counter.sv @@
// wifi_frame_statistics_counter: top level of the 802.11 frame statistics block
// depends on wfsc_pkg, wfsc_front, wfsc_fifo, wfsc_back and wfsc_div
//
// usage
//   input channel (in_valid/in_ready) carries one descriptor word: a received
//   frame, a snapshot request or a session clear
//   output channel (out_valid/out_ready) carries the 18 statistic words of a
//   snapshot, ids 0 to 17, with last on the final one
//   apb port holds capture_enable at address 0; pready is always high
// throughput and snapshot sequence
//   the back end executes a frame or clear straight from idle, so with the
//   two-word queue the block sustains one frame per cycle outside snapshots
//   a snapshot runs two passes of the shared restoring divider, average
//   rssi then packet rate, then streams 18 words; commands wait in the queue
//   until the last word is loaded
// reset
//   synchronous rst clears all counters, start times, queue and capture_enable
// stalls
//   a stalled receiver holds the output word; the back end waits, the queue
//   fills and in_ready falls only when both queue slots are taken
module wifi_frame_statistics_counter #(
  parameter int COUNTER_BITS = wfsc_pkg::COUNTER_BITS_DEF,
  parameter int RATE_SCALE   = wfsc_pkg::RATE_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [1:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic [1:0]                          radio_class,
  input  logic                                payload_present,
  input  logic [11:0]                         frame_length,
  input  logic [7:0]                          rx_status,
  input  logic [7:0]                          frame_control_low,
  input  logic signed [7:0]                   rssi,
  input  logic [31:0]                         now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wfsc_pkg::STAT_W-1:0]         stat_id,
  output logic signed [wfsc_pkg::VALUE_W-1:0] stat_value,
  output logic                                last
);
  import wfsc_pkg::*;

  logic capture_enable;
  logic push;
  cmd_t push_cmd;
  logic not_empty;
  logic pop;
  cmd_t head;

  // register file: one bit at address 0, reads return it at any address
  assign pready = 1'b1;
  assign prdata = {31'd0, capture_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      capture_enable <= pwdata[0];
    end
  end

  // front: classify the descriptor word into a queue command
  wfsc_front u_front (
    .capture_enable    (capture_enable),
    .operation         (operation),
    .radio_class       (radio_class),
    .payload_present   (payload_present),
    .frame_length      (frame_length),
    .rx_status         (rx_status),
    .frame_control_low (frame_control_low),
    .rssi              (rssi),
    .now_ms            (now_ms),
    .push              (push),
    .cmd               (push_cmd),
    .accept            (in_valid && in_ready)
  );

  // queue decouples accept from execution
  wfsc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (in_ready),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // back: counters, divider and snapshot streaming
  wfsc_back #(
    .COUNTER_BITS (COUNTER_BITS),
    .RATE_SCALE   (RATE_SCALE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (not_empty),
    .cmd        (head),
    .cmd_pop    (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat_id    (stat_id),
    .stat_value (stat_value),
    .last       (last)
  );

  // last marks exactly the elapsed-time word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (stat_id == ID_ELAPSED)))
    else $error("last flag out of step with stat id");

  // no statistic id beyond the elapsed-time word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stat_id <= ID_ELAPSED)
    else $error("stat id out of range");

  // queue never pops while empty
  assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("command popped from empty queue");

endmodule

@@ rtl/wfsc_front.sv @@
// wfsc_front: accepts input words and classifies them into queue commands
// depends on wfsc_pkg
module wfsc_front (
  input  logic               capture_enable,
  input  logic [1:0]         operation,
  input  logic [1:0]         radio_class,
  input  logic               payload_present,
  input  logic [11:0]        frame_length,
  input  logic [7:0]         rx_status,
  input  logic [7:0]         frame_control_low,
  input  logic signed [7:0]  rssi,
  input  logic [31:0]        now_ms,
  output logic               push,
  output wfsc_pkg::cmd_t     cmd,
  input  logic               accept
);
  import wfsc_pkg::*;

  logic [1:0] ftype;
  logic [4:0] sub;
  logic       bad;

  assign ftype = frame_control_low[3:2];
  assign sub   = subtype_map(frame_control_low[7:4]);

  always_comb begin
    bad = !payload_present || (frame_length < 12'd2) || (rx_status != 8'd0) ||
          (frame_control_low[1:0] != 2'd0) || (ftype == 2'd3) ||
          (radio_class != ftype + 2'd1);
    cmd.ftype   = ftype;
    cmd.sub_hit = sub[4];
    cmd.sub_idx = sub[3:0];
    cmd.rssi    = rssi;
    cmd.now_ms  = now_ms;
    cmd.kind    = CMD_FRAME;
    push        = 1'b0;
    case (operation)
      OP_FRAME: begin
        cmd.kind = bad ? CMD_BAD : CMD_FRAME;
        push     = accept && capture_enable && (radio_class != CLASS_MISC);
      end
      OP_SNAP: begin
        cmd.kind = CMD_SNAP;
        push     = accept;
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
        push     = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/wfsc_fifo.sv @@
// wfsc_fifo: two-entry command queue between front and back
// depends on wfsc_pkg
module wfsc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wfsc_pkg::cmd_t  push_cmd,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output wfsc_pkg::cmd_t  head
);
  import wfsc_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

endmodule

@@ rtl/wfsc_div.sv @@
// wfsc_div: restoring divider, one quotient bit per cycle
// depends on wfsc_pkg
module wfsc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wfsc_pkg::DIV_W-1:0]  dividend,
  input  logic [wfsc_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [wfsc_pkg::DIV_W-1:0]  quotient
);
  import wfsc_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem[DEN_W-1:0], quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? shifted - {1'b0, den} : shifted;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

@@ rtl/wfsc_back.sv @@
// wfsc_back: statistics state, command execution and snapshot sequencer
// depends on wfsc_pkg and wfsc_div
module wfsc_back #(
  parameter int COUNTER_BITS = wfsc_pkg::COUNTER_BITS_DEF,
  parameter int RATE_SCALE   = wfsc_pkg::RATE_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  input  wfsc_pkg::cmd_t                      cmd,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wfsc_pkg::STAT_W-1:0]         stat_id,
  output logic signed [wfsc_pkg::VALUE_W-1:0] stat_value,
  output logic                                last
);
  import wfsc_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam logic [CB-1:0] CMAX = '1;

  logic [CB-1:0]            counters [NUM_CNT];
  logic [CB-1:0]            pkts;
  logic [CB-1:0]            rcount;
  logic signed [TOTAL_W-1:0] rtotal;
  logic signed [7:0]        peak;
  logic [31:0]              istart;
  logic [31:0]              sstart;

  back_state_t              state, state_next;
  logic [STAT_W-1:0]        eidx;
  logic [31:0]              ival;
  logic [31:0]              elap;
  logic [DIV_W-1:0]         prod;
  logic signed [AVG_W-1:0]  avg;
  logic [RATE_W-1:0]        rate;

  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [DIV_W-1:0]         div_q;
  logic                     emit_load;
  logic                     do_cmd;

  logic [NUM_CNT-1:0]       inc;
  logic [NUM_CNT-1:0]       sat;
  logic                     rssi_drop;
  logic [2:0]               n_ovf;
  logic [CB:0]              ovf_sum;
  logic [TOTAL_W-1:0]       abs_total;

  wfsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign abs_total = rtotal[TOTAL_W-1] ? TOTAL_W'(-rtotal) : TOTAL_W'(rtotal);
  assign div_num   = (state == ST_IDLE) ? DIV_W'(abs_total) : prod;
  assign div_den   = (state == ST_IDLE) ? DEN_W'(rcount) : ival;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (cmd_valid && cmd.kind == CMD_SNAP) state_next = ST_DIV_AVG;
      ST_DIV_AVG:  if (div_done) state_next = ST_DIV_RATE;
      ST_DIV_RATE: if (div_done) state_next = ST_EMIT;
      ST_EMIT:     if (emit_load && eidx == ID_ELAPSED) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    do_cmd    = (state == ST_IDLE) && cmd_valid;
    cmd_pop   = do_cmd;
    div_start = (do_cmd && cmd.kind == CMD_SNAP) || (state == ST_DIV_AVG && div_done);
    emit_load = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  // counter increments of one frame command
  always_comb begin
    inc = '0;
    if (do_cmd && cmd.kind == CMD_FRAME) begin
      inc[ID_TOTAL[3:0]] = 1'b1;
      inc[4'(cmd.ftype) + ID_MGMT[3:0]] = 1'b1;
      if (cmd.ftype == 2'd0 && cmd.sub_hit) inc[cmd.sub_idx] = 1'b1;
    end
    if (do_cmd && cmd.kind == CMD_BAD) inc[ID_MALFORMED[3:0]] = 1'b1;
    for (int i = 0; i < NUM_CNT; i++) sat[i] = (counters[i] == CMAX);
    rssi_drop = do_cmd && cmd.kind == CMD_FRAME && rcount == CMAX;
    n_ovf   = 3'($countones(inc & sat)) + 3'(rssi_drop);
    ovf_sum = {1'b0, counters[ID_OVERFLOW[3:0]]} + (CB+1)'(n_ovf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < NUM_CNT; i++) counters[i] <= '0;
      pkts   <= '0;
      rcount <= '0;
      rtotal <= '0;
      peak   <= '0;
      istart <= '0;
      sstart <= '0;
      eidx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_cmd && cmd.kind == CMD_CLEAR) begin
        for (int i = 0; i < NUM_CNT; i++) counters[i] <= '0;
        pkts   <= '0;
        rcount <= '0;
        rtotal <= '0;
        peak   <= '0;
        istart <= cmd.now_ms;
        sstart <= cmd.now_ms;
      end else begin
        for (int i = 0; i < NUM_CNT - 1; i++) begin
          if (inc[i] && !sat[i]) counters[i] <= counters[i] + CB'(1);
        end
        counters[ID_OVERFLOW[3:0]] <= ovf_sum[CB] ? CMAX : ovf_sum[CB-1:0];
        if (do_cmd && cmd.kind == CMD_FRAME) begin
          if (pkts != CMAX) pkts <= pkts + CB'(1);
          if (rcount != CMAX) begin
            if (rcount == '0 || cmd.rssi > peak) peak <= cmd.rssi;
            rtotal <= rtotal + TOTAL_W'(cmd.rssi);
            rcount <= rcount + CB'(1);
          end
        end
        if (do_cmd && cmd.kind == CMD_SNAP) begin
          istart <= cmd.now_ms;
          pkts   <= '0;
        end
      end
      if (div_start && state == ST_IDLE) eidx <= '0;
      else if (emit_load) eidx <= eidx + STAT_W'(1);
      if (emit_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // snapshot operands and results
  always_ff @(posedge clk) begin
    if (do_cmd && cmd.kind == CMD_SNAP) begin
      ival <= cmd.now_ms - istart;
      elap <= cmd.now_ms - sstart;
      prod <= DIV_W'(pkts) * DIV_W'(RATE_SCALE);
    end
    if (state == ST_DIV_AVG && div_done) begin
      if (rcount == '0) avg <= '0;
      else if (rtotal[TOTAL_W-1]) avg <= -AVG_W'(div_q);
      else avg <= AVG_W'(div_q);
    end
    if (state == ST_DIV_RATE && div_done) begin
      if (ival == 32'd0) rate <= '0;
      else if (div_q[DIV_W-1:RATE_W] != '0) rate <= '1;
      else rate <= div_q[RATE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      stat_id <= eidx;
      last    <= (eidx == ID_ELAPSED);
      case (eidx)
        ID_AVG:      stat_value <= VALUE_W'(avg);
        ID_PEAK:     stat_value <= (rcount == '0) ? '0 : VALUE_W'(peak);
        ID_RATE:     stat_value <= {1'b0, rate};
        ID_INTERVAL: stat_value <= {1'b0, ival};
        ID_ELAPSED:  stat_value <= {1'b0, elap};
        default:     stat_value <= {{(VALUE_W-CB){1'b0}}, counters[eidx[3:0]]};
      endcase
    end
  end

endmodule

@@ sim/wfsc_checker.sv @@
// wfsc_checker: watches the descriptor and statistic channels of the frame statistics
// counter, predicts every snapshot word and compares; depends on wfsc_pkg
module wfsc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cap_en,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic [1:0]                          radio_class,
  input  logic                                payload_present,
  input  logic [11:0]                         frame_length,
  input  logic [7:0]                          rx_status,
  input  logic [7:0]                          frame_control_low,
  input  logic signed [7:0]                   rssi,
  input  logic [31:0]                         now_ms,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [wfsc_pkg::STAT_W-1:0]         stat_id,
  input  logic signed [wfsc_pkg::VALUE_W-1:0] stat_value,
  input  logic                                last,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wfsc_pkg::*;

  localparam logic [31:0] SAT = 32'hFFFF_FFFF;

  typedef struct {
    logic [STAT_W-1:0]         id;
    logic signed [VALUE_W-1:0] value;
    logic                      fin;
  } stat_word_t;

  stat_word_t stat_q[$];

  logic [31:0]        counts[NUM_CNT];
  logic [31:0]        win_pkts;
  longint             rssi_sum;
  logic [31:0]        rssi_n;
  logic signed [7:0]  rssi_max;
  logic [31:0]        win_start;
  logic [31:0]        sess_start;

  assign pending = stat_q.size();

  task automatic bump(input int idx);
    if (counts[idx] != SAT) counts[idx]++;
    else if (counts[ID_OVERFLOW] != SAT) counts[ID_OVERFLOW]++;
  endtask

  task automatic zero_session(input logic [31:0] t);
    foreach (counts[i]) counts[i] = '0;
    win_pkts = '0; rssi_sum = 0; rssi_n = '0; rssi_max = '0;
    win_start = t; sess_start = t;
  endtask

  task automatic push_stat(input int id, input longint v);
    stat_word_t w;
    w.id = STAT_W'(id); w.value = v[VALUE_W-1:0]; w.fin = (id == ID_ELAPSED);
    stat_q.push_back(w);
  endtask

  task automatic count_frame();
    logic [1:0] ft;
    logic       bad;
    ft = frame_control_low[3:2];
    if (radio_class == CLASS_MISC || !cap_en) return;
    bad = !payload_present || frame_length < 2 || rx_status != 0 ||
          frame_control_low[1:0] != 0 || ft == 2'd3 || radio_class != ft + 2'd1;
    if (bad) begin
      bump(ID_MALFORMED);
      return;
    end
    bump(ID_TOTAL);
    if (win_pkts != SAT) win_pkts++;
    case (ft)
      2'd0: begin
        bump(ID_MGMT);
        case (frame_control_low[7:4])
          4'd0:  bump(ID_ASSOC_REQ);
          4'd1:  bump(ID_ASSOC_RESP);
          4'd4:  bump(ID_PROBE_REQ);
          4'd5:  bump(ID_PROBE_RESP);
          4'd8:  bump(ID_BEACON);
          4'd10: bump(ID_DISASSOC);
          4'd12: bump(ID_DEAUTH);
          default: ;
        endcase
      end
      2'd1: bump(ID_CTRL);
      default: bump(ID_DATA);
    endcase
    if (rssi_n != SAT) begin
      if (rssi_n == 0 || rssi > rssi_max) rssi_max = rssi;
      rssi_sum += rssi;
      rssi_n++;
    end else bump(ID_OVERFLOW);
  endtask

  task automatic predict_snapshot();
    logic [31:0] ivl, ela;
    longint      avg, pk;
    longint unsigned rate;
    ivl = now_ms - win_start;
    ela = now_ms - sess_start;
    avg = 0; pk = 0; rate = 0;
    if (rssi_n != 0) begin
      avg = rssi_sum / longint'(rssi_n);
      pk = rssi_max;
    end
    if (ivl != 0) begin
      rate = (longint'(win_pkts) * RATE_SCALE_DEF) / ivl;
      if (rate > SAT) rate = SAT;
    end
    for (int i = 0; i < NUM_CNT; i++) push_stat(i, longint'(counts[i]));
    push_stat(ID_AVG, avg);
    push_stat(ID_PEAK, pk);
    push_stat(ID_RATE, longint'(rate));
    push_stat(ID_INTERVAL, longint'(ivl));
    push_stat(ID_ELAPSED, longint'(ela));
    win_start = now_ms;
    win_pkts = '0;
  endtask

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    stat_word_t e;
    if (rst) begin
      zero_session('0);
      stat_q.delete();
      fail_count <= 0;
    end else begin
      // result side first: a word leaving now was predicted by an earlier descriptor
      if (out_valid && out_ready) begin
        if (stat_q.size() == 0) report($sformatf("unexpected word id %0d", stat_id));
        else begin
          e = stat_q.pop_front();
          if (stat_id !== e.id || stat_value !== e.value || last !== e.fin)
            report($sformatf("exp id %0d val %0d last %0b, got id %0d val %0d last %0b",
                             e.id, e.value, e.fin, stat_id, stat_value, last));
        end
      end
      if (in_valid && in_ready) begin
        case (operation)
          OP_FRAME: count_frame();
          OP_SNAP:  predict_snapshot();
          OP_CLEAR: zero_session(now_ms);
          default: ;
        endcase
      end
    end
  end
endmodule

@@ sim/wifi_frame_statistics_counter_tb.sv @@
// wifi_frame_statistics_counter_tb: stimulus and verdict for the frame statistics block
// depends on wfsc_pkg, the block's rtl and wfsc_checker
module wifi_frame_statistics_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wfsc_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic [1:0] operation = '0, radio_class = '0;
  logic payload_present = 0;
  logic [11:0] frame_length = '0;
  logic [7:0] rx_status = '0, frame_control_low = '0;
  logic signed [7:0] rssi = '0;
  logic [31:0] now_ms = '0;
  logic out_valid, out_ready = 0, last;
  logic [STAT_W-1:0] stat_id;
  logic signed [VALUE_W-1:0] stat_value;
  logic cap_en = 0;      // mirror of capture_enable for the checker
  int fail_count, pending, cycles = 0;
  logic [31:0] clock_ms = 0;   // monotonic-ish time base for snapshots
  int rx_hold = 0;             // cycles left in a long receiver stall

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  wifi_frame_statistics_counter dut (.*);

  wfsc_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, a few long
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 0;
    end else if ($urandom_range(0, 199) == 0) begin
      rx_hold = $urandom_range(20, 80);
      out_ready <= 0;
    end else if ($urandom_range(0, 2) == 0) out_ready <= 0;
    else out_ready <= 1;
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (n) @(negedge clk);
  endtask

  // hold one word until accepted
  task automatic send(input logic [1:0] op, input logic [1:0] cls, input logic pay,
                      input logic [11:0] len, input logic [7:0] st, input logic [7:0] fc,
                      input logic [7:0] rs, input logic [31:0] t);
    idle_gap();
    operation <= op; radio_class <= cls; payload_present <= pay;
    frame_length <= len; rx_status <= st; frame_control_low <= fc;
    rssi <= rs; now_ms <= t; in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  // well-formed frame of a given type
  task automatic good_frame(input logic [1:0] ft, input logic [3:0] sub, input logic [7:0] rs);
    send(OP_FRAME, ft + 2'd1, 1, 12'($urandom_range(2, 4095)), 0, {sub, ft, 2'b00}, rs,
         $urandom());
  endtask

  task automatic snap(input logic [31:0] t);
    send(OP_SNAP, 2'($urandom()), 1'($urandom()), 12'($urandom()), 8'($urandom()),
         8'($urandom()), 8'($urandom()), t);
  endtask

  // drain all predicted words, then allow the back end to settle
  task automatic quiesce();
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_capture(input logic v);
    quiesce();
    psel <= 1; pwrite <= 1; paddr <= 2'd0; pwdata <= {31'($urandom()), v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cap_en = v;
  endtask

  task automatic random_item();
    int r;
    logic [3:0] subs[7] = '{0, 1, 4, 5, 8, 10, 12};
    r = $urandom_range(0, 99);
    if (r < 60)
      good_frame(2'($urandom_range(0, 2)),
                 ($urandom_range(0, 1)) ? subs[$urandom_range(0, 6)] : 4'($urandom()),
                 8'($urandom()));
    else if (r < 82)
      // noise: fully random descriptor, mostly malformed or misc
      send(OP_FRAME, 2'($urandom()), 1'($urandom()), 12'($urandom()),
           ($urandom_range(0, 1)) ? 8'd0 : 8'($urandom()),
           8'($urandom()), 8'($urandom()), $urandom());
    else if (r < 93) begin
      clock_ms += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5000);
      snap(clock_ms);
    end else if (r < 97) begin
      clock_ms += $urandom_range(0, 100);
      send(OP_CLEAR, 2'($urandom()), 1'($urandom()), 12'($urandom()), 8'($urandom()),
           8'($urandom()), 8'($urandom()), clock_ms);
    end else
      send(2'd3, 2'($urandom()), 1'($urandom()), 12'($urandom()), 8'($urandom()),
           8'($urandom()), 8'($urandom()), $urandom());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // capture off: frames dropped
    good_frame(0, 8, 8'sd10);
    snap(32'd0);
    write_capture(1);

    // directed: each type, subtypes, rssi extremes, malformed causes
    good_frame(0, 0, 8'h80);
    good_frame(0, 1, 8'h7F);
    good_frame(0, 4, 8'hFF);
    good_frame(0, 5, 8'h00);
    good_frame(0, 8, 8'hC0);
    good_frame(0, 10, 8'h01);
    good_frame(0, 12, 8'h80);
    good_frame(0, 15, 8'h20);
    good_frame(1, 4'hF, 8'hAA);
    good_frame(2, 4'hA, 8'h55);
    send(OP_FRAME, 2'd0, 1, 12'd100, 0, 8'h08, 8'h10, 0);        // misc class
    send(OP_FRAME, 2'd1, 0, 12'd100, 0, 8'h00, 8'h10, 0);        // no payload
    send(OP_FRAME, 2'd1, 1, 12'd1, 0, 8'h00, 8'h10, 0);          // too short
    send(OP_FRAME, 2'd1, 1, 12'hFFF, 8'hFF, 8'h00, 8'h10, 0);    // rx error
    send(OP_FRAME, 2'd1, 1, 12'd2, 0, 8'h03, 8'h10, 0);          // version
    send(OP_FRAME, 2'd3, 1, 12'd50, 0, 8'h0C, 8'h10, 0);         // type 3
    send(OP_FRAME, 2'd3, 1, 12'd50, 0, 8'h04, 8'h10, 0);         // class mismatch
    send(2'd3, 2'd1, 1, 12'd50, 0, 8'h00, 8'h10, 32'hFFFF_FFFF); // unused op
    snap(32'hFFFF_FFFF);                                          // maximum interval
    snap(32'hFFFF_FFFF);                                          // zero interval
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 32'd5);
    snap(32'd3);                                                  // wraps, no samples
    clock_ms = 32'd3;

    // sender hold-off until the output drains
    quiesce();

    for (int i = 0; i < 360; i++) begin
      if (i == 120) write_capture(0);
      if (i == 160) write_capture(1);
      random_item();
    end
    snap(clock_ms + 32'd1000);

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
